/* rtl/crad_pkg.sv */
package crad_pkg;

  localparam int COORD_W   = 24;
  localparam int RAD_W     = 32;

  // coordinate differences and their squares
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W - 1;
  localparam int D2_W      = 2 * DIFF_W;
  localparam int XPROD_W   = 2 * DIFF_W;
  localparam int CROSS_W   = 2 * DIFF_W + 1;
  localparam int CMAG_W    = 2 * DIFF_W;

  // den = (2*cross)^2, num = a2*b2*c2
  localparam int DEN_W     = 2 * (CMAG_W + 1);
  localparam int AB_W      = 2 * D2_W;
  localparam int NUM_W     = AB_W + D2_W;
  localparam int QUO_W     = 2 * RAD_W;
  localparam int DIV_W     = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  localparam int MUL_CHUNK = 26;
  localparam int MUL_LAT   = 3;
  localparam int FRONT_LAT = 4;

  localparam int QDEPTH    = 8;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int CRED_W    = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t middle_x;
    coord_t middle_y;
    coord_t last_x;
    coord_t last_y;
  } crad_in_t;

  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic             degenerate;
  } crad_out_t;

  // job handed from the front to the back
  typedef struct packed {
    logic [D2_W-1:0]   a2;
    logic [D2_W-1:0]   b2;
    logic [D2_W-1:0]   c2;
    logic [CMAG_W-1:0] cmag;
    logic              zero;
  } crad_job_t;

endpackage

/* rtl/crad_front.sv */
module crad_front
  import crad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  crad_in_t  in_data,
  input  logic      pop,
  output logic      push,
  output crad_job_t job
);

  logic                  accept;
  logic [CRED_W-1:0]     cred_r, cred_nxt;
  logic [FRONT_LAT-1:0]  vld_r, vld_nxt;

  diff_t                 dax_r, day_r, u1_r, u2_r, v1_r, v2_r;
  logic [SQ_W-1:0]       sax_r, say_r, su1_r, su2_r, sv1_r, sv2_r;
  logic signed [XPROD_W-1:0] p_r, q_r;
  logic [D2_W-1:0]       a2_r, b2_r, c2_r;
  logic signed [CROSS_W-1:0] cross_r;
  crad_job_t             job_r;

  logic signed [2*DIFF_W-1:0] m_ax, m_ay, m_u1, m_u2, m_v1, m_v2, m_p, m_q;

  // one credit per beat between accept and its pop from the queue
  assign busy   = (cred_r == CRED_W'(QDEPTH));
  assign accept = start & ~busy;

  always_comb begin
    cred_nxt = cred_r;
    priority if (accept && !pop) begin
      cred_nxt = CRED_W'(cred_r + 1'b1);
    end else if (!accept && pop) begin
      cred_nxt = CRED_W'(cred_r - 1'b1);
    end
    vld_nxt = {vld_r[FRONT_LAT-2:0], accept};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
      vld_r  <= '0;
    end else begin
      cred_r <= cred_nxt;
      vld_r  <= vld_nxt;
    end
  end

  assign m_ax = dax_r * dax_r;
  assign m_ay = day_r * day_r;
  assign m_u1 = u1_r * u1_r;
  assign m_u2 = u2_r * u2_r;
  assign m_v1 = v1_r * v1_r;
  assign m_v2 = v2_r * v2_r;
  assign m_p  = u1_r * v1_r;
  assign m_q  = u2_r * v2_r;

  always_ff @(posedge clk) begin
    dax_r <= diff_t'(signed'(in_data.middle_x)) - diff_t'(signed'(in_data.last_x));
    day_r <= diff_t'(signed'(in_data.middle_y)) - diff_t'(signed'(in_data.last_y));
    u1_r  <= diff_t'(signed'(in_data.middle_x)) - diff_t'(signed'(in_data.first_x));
    u2_r  <= diff_t'(signed'(in_data.middle_y)) - diff_t'(signed'(in_data.first_y));
    v1_r  <= diff_t'(signed'(in_data.last_y)) - diff_t'(signed'(in_data.first_y));
    v2_r  <= diff_t'(signed'(in_data.last_x)) - diff_t'(signed'(in_data.first_x));

    sax_r <= m_ax[SQ_W-1:0];
    say_r <= m_ay[SQ_W-1:0];
    su1_r <= m_u1[SQ_W-1:0];
    su2_r <= m_u2[SQ_W-1:0];
    sv1_r <= m_v1[SQ_W-1:0];
    sv2_r <= m_v2[SQ_W-1:0];
    p_r   <= m_p;
    q_r   <= m_q;

    a2_r    <= D2_W'(sax_r) + D2_W'(say_r);
    b2_r    <= D2_W'(sv2_r) + D2_W'(sv1_r);
    c2_r    <= D2_W'(su1_r) + D2_W'(su2_r);
    cross_r <= CROSS_W'(p_r) - CROSS_W'(q_r);

    job_r.a2   <= a2_r;
    job_r.b2   <= b2_r;
    job_r.c2   <= c2_r;
    job_r.cmag <= cross_r[CROSS_W-1] ? CMAG_W'(-cross_r) : CMAG_W'(cross_r);
    job_r.zero <= (cross_r == '0);
  end

  assign push = vld_r[FRONT_LAT-1];
  assign job  = job_r;

`ifndef SYNTHESIS
  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= CRED_W'(QDEPTH))
    else $error("credit count above queue depth");
  a_push_credit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cred_r != '0)
    else $error("beat reaches queue without a credit");
`endif

endmodule

/* rtl/crad_queue.sv */
module crad_queue
  import crad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  crad_job_t wr_job,
  output logic      pop,
  output logic      rd_vld,
  output crad_job_t rd_job
);

  crad_job_t         mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [CRED_W-1:0] cnt_r, cnt_nxt;
  crad_job_t         rd_job_r;
  logic              rd_vld_r;

  // the back end never stalls: drain whenever something is held
  assign pop    = (cnt_r != '0);
  assign rd_job = rd_job_r;
  assign rd_vld = rd_vld_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= wr_job;
    end
    if (pop) begin
      rd_job_r <= mem[rd_r];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    priority if (push && !pop) begin
      cnt_nxt = CRED_W'(cnt_r + 1'b1);
    end else if (!push && pop) begin
      cnt_nxt = CRED_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r     <= '0;
      rd_r     <= '0;
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= QPTR_W'(wr_r + 1'b1);
      end
      if (pop) begin
        rd_r <= QPTR_W'(rd_r + 1'b1);
      end
      cnt_r    <= cnt_nxt;
      rd_vld_r <= pop;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CRED_W'(QDEPTH))
    else $error("queue overflow");
`endif

endmodule

/* rtl/crad_mul.sv */
module crad_mul
  import crad_pkg::*;
#(
  parameter int A_W = 50,
  parameter int B_W = 50,
  parameter int K   = 26
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  localparam int NA  = (A_W + K - 1) / K;
  localparam int NB  = (B_W + K - 1) / K;
  localparam int AP  = NA * K;
  localparam int BP  = NB * K;
  localparam int RW  = BP + K;
  localparam int P_W = A_W + B_W;

  logic [AP-1:0]    a_ext;
  logic [BP-1:0]    b_ext;
  logic [2*K-1:0]   pp_r [NA][NB];
  logic [RW-1:0]    row_r [NA];
  logic [RW-1:0]    row_nxt [NA];
  logic [P_W-1:0]   p_r, p_nxt;

  assign a_ext = AP'(a);
  assign b_ext = BP'(b);

  // partial products, then row sums, then the final sum
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= (2*K)'(a_ext[i*K +: K]) * (2*K)'(b_ext[j*K +: K]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (j * K));
      end
    end
    p_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      p_nxt = p_nxt + (P_W'(row_r[i]) << (i * K));
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    p_r   <= p_nxt;
  end

  assign p = p_r;

endmodule

/* rtl/crad_back.sv */
module crad_back
  import crad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  crad_job_t in_job,
  output logic      out_valid,
  output crad_out_t out_data
);

  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = RAD_W;
  localparam int BACK_LAT   = 1 + 2 * MUL_LAT + 1 + DIV_STEPS + SQRT_STEPS + 1;

  logic                b0_v_r;
  crad_job_t           b0_r;

  logic [DEN_W-1:0]    den_p;
  logic [AB_W-1:0]     ab_p;
  logic [NUM_W-1:0]    num_p;

  logic [MUL_LAT-1:0]  m1_v_r, m2_v_r, z1_r, z2_r;
  logic [D2_W-1:0]     c2_d_r [MUL_LAT];
  logic [DEN_W-1:0]    den_d_r [MUL_LAT];

  logic [DIV_W-1:0]    rem_r [DIV_STEPS+1];
  logic [DEN_W-1:0]    dvs_r [DIV_STEPS+1];
  logic [QUO_W-1:0]    quo_r [DIV_STEPS+1];
  logic                dg_r  [DIV_STEPS+1];
  logic [DIV_STEPS:0]  dv_v_r;

  logic [QUO_W-1:0]    op_r  [SQRT_STEPS];
  logic [QUO_W-1:0]    res_r [SQRT_STEPS];
  logic                sg_r  [SQRT_STEPS];
  logic [SQRT_STEPS-1:0] sq_v_r;

  logic                out_v_r;
  crad_out_t           out_r;

  always_ff @(posedge clk) begin
    b0_r <= in_job;
  end

  crad_mul #(.A_W(CMAG_W + 1), .B_W(CMAG_W + 1), .K(MUL_CHUNK)) u_den (
    .clk (clk),
    .a   ({b0_r.cmag, 1'b0}),
    .b   ({b0_r.cmag, 1'b0}),
    .p   (den_p)
  );

  crad_mul #(.A_W(D2_W), .B_W(D2_W), .K(MUL_CHUNK)) u_ab (
    .clk (clk),
    .a   (b0_r.a2),
    .b   (b0_r.b2),
    .p   (ab_p)
  );

  crad_mul #(.A_W(AB_W), .B_W(D2_W), .K(MUL_CHUNK)) u_num (
    .clk (clk),
    .a   (ab_p),
    .b   (c2_d_r[MUL_LAT-1]),
    .p   (num_p)
  );

  // align c2 with a2*b2, then den with the full product
  always_ff @(posedge clk) begin
    c2_d_r[0]  <= b0_r.c2;
    den_d_r[0] <= den_p;
    for (int i = 1; i < MUL_LAT; i++) begin
      c2_d_r[i]  <= c2_d_r[i-1];
      den_d_r[i] <= den_d_r[i-1];
    end
    z1_r <= {z1_r[MUL_LAT-2:0], b0_r.zero};
    z2_r <= {z2_r[MUL_LAT-2:0], z1_r[MUL_LAT-1]};
  end

  // load the divider, and flag collinear points and radii of 2^32 or more
  always_ff @(posedge clk) begin
    rem_r[0] <= DIV_W'(num_p);
    dvs_r[0] <= den_d_r[MUL_LAT-1];
    quo_r[0] <= '0;
    dg_r[0]  <= z2_r[MUL_LAT-1] |
                (DIV_W'(num_p) >= (DIV_W'(den_d_r[MUL_LAT-1]) << QUO_W));
  end

  // restoring division, one quotient bit per stage
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - s;
    logic [DIV_W-1:0] dsh, rem_nxt;
    logic             take;

    assign dsh     = DIV_W'(dvs_r[s]) << SH;
    assign take    = (rem_r[s] >= dsh);
    assign rem_nxt = take ? rem_r[s] - dsh : rem_r[s];

    always_ff @(posedge clk) begin
      rem_r[s+1] <= rem_nxt;
      dvs_r[s+1] <= dvs_r[s];
      quo_r[s+1] <= quo_r[s] | (QUO_W'(take) << SH);
      dg_r[s+1]  <= dg_r[s];
    end
  end

  // digit-by-digit square root of the quotient
  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    localparam logic [QUO_W-1:0] ONE = QUO_W'(1) << (QUO_W - 2 - 2 * s);
    logic [QUO_W-1:0] op_in, res_in, trial;
    logic             g_in, ge;

    if (s == 0) begin : g_first
      assign op_in  = quo_r[DIV_STEPS];
      assign res_in = '0;
      assign g_in   = dg_r[DIV_STEPS];
    end else begin : g_rest
      assign op_in  = op_r[s-1];
      assign res_in = res_r[s-1];
      assign g_in   = sg_r[s-1];
    end

    assign trial = res_in + ONE;
    assign ge    = (op_in >= trial);

    always_ff @(posedge clk) begin
      op_r[s]  <= ge ? op_in - trial : op_in;
      res_r[s] <= ge ? (res_in >> 1) + ONE : (res_in >> 1);
      sg_r[s]  <= g_in;
    end
  end

  always_ff @(posedge clk) begin
    out_r.radius     <= sg_r[SQRT_STEPS-1] ? '1 : res_r[SQRT_STEPS-1][RAD_W-1:0];
    out_r.degenerate <= sg_r[SQRT_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      m1_v_r  <= '0;
      m2_v_r  <= '0;
      dv_v_r  <= '0;
      sq_v_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      b0_v_r  <= in_vld;
      m1_v_r  <= {m1_v_r[MUL_LAT-2:0], b0_v_r};
      m2_v_r  <= {m2_v_r[MUL_LAT-2:0], m1_v_r[MUL_LAT-1]};
      dv_v_r  <= {dv_v_r[DIV_STEPS-1:0], m2_v_r[MUL_LAT-1]};
      sq_v_r  <= {sq_v_r[SQRT_STEPS-2:0], dv_v_r[DIV_STEPS]};
      out_v_r <= sq_v_r[SQRT_STEPS-1];
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld |-> ##BACK_LAT out_valid)
    else $error("result strobe misaligned with job");
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld && in_job.zero |-> ##BACK_LAT out_data.degenerate)
    else $error("collinear job not flagged");
`endif

endmodule

/* rtl/circumradius_of_three_points.sv */
// channel  | ports                   | handshake
// ---------+-------------------------+--------------------------------------
// input    | start, busy, in_data    | beat taken when start && !busy
// result   | out_valid, out_data     | one-cycle strobe, cannot be held off
//
// One beat enters per cycle; busy only rises if the front-to-back queue
// runs out of credits, which a free-running back end never lets happen.
// From accept to strobe a beat passes the front's difference, square, sum
// and job registers, queue write and read, back input register, two chained
// multipliers, range check, 64 divider and 32 root stages, output register.
// Synchronous active-low reset clears valids, credits and queue pointers.
module circumradius_of_three_points
  import crad_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  crad_in_t  in_data,
  output logic      out_valid,
  output crad_out_t out_data
);

  logic      push, pop, q_vld;
  crad_job_t f_job, q_job;

  crad_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .pop     (pop),
    .push    (push),
    .job     (f_job)
  );

  crad_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (f_job),
    .pop    (pop),
    .rd_vld (q_vld),
    .rd_job (q_job)
  );

  crad_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (q_vld),
    .in_job    (q_job),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* bench/tb_circumradius_of_three_points.sv */
module tb_circumradius_of_three_points;
  import crad_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          LATENCY     = 110;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  crad_in_t  in_data = '0;
  logic      out_valid;
  crad_out_t out_data;

  crad_out_t   radius_q[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_degen = 0;
  int unsigned cycles = 0;
  int          idle_pct = 0;

  circumradius_of_three_points dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [255:0] dist2(logic signed [63:0] dx, logic signed [63:0] dy);
    logic [63:0] s;
    s = dx * dx + dy * dy;
    return {192'd0, s};
  endfunction

  // exact floor(sqrt(a2*b2*c2 / (4*xprod^2))), saturated
  function automatic crad_out_t circumradius(crad_in_t p);
    logic signed [63:0] ax, ay, bx, by, cx, cy, xprod;
    logic [63:0]  cmag, q;
    logic [255:0] a2, b2, c2, num, den, quo;
    logic [31:0]  r, cand;
    crad_out_t    res;
    ax = p.first_x;  ay = p.first_y;
    bx = p.middle_x; by = p.middle_y;
    cx = p.last_x;   cy = p.last_y;
    xprod = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    res.radius = '1;
    res.degenerate = 1'b1;
    if (xprod == 0) return res;
    a2 = dist2(bx - cx, by - cy);
    b2 = dist2(ax - cx, ay - cy);
    c2 = dist2(ax - bx, ay - by);
    num = a2 * b2 * c2;
    cmag = (xprod < 0) ? -xprod : xprod;
    den = ({192'd0, cmag} * {192'd0, cmag}) << 2;
    if ((den << 64) <= num) return res;
    quo = num / den;
    q = quo[63:0];
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = r | (32'd1 << b);
      if ({32'd0, cand} * {32'd0, cand} <= q) r = cand;
    end
    res.radius = r;
    res.degenerate = 1'b0;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    crad_out_t want;
    if (rst_n && out_valid) begin
      if (radius_q.size() == 0) begin
        report("unexpected beat", out_data.radius, 32'd0);
      end else begin
        want = radius_q.pop_front();
        n_checked++;
        if (want.degenerate) n_degen++;
        if (out_data.radius !== want.radius)
          report("radius", out_data.radius, want.radius);
        if (out_data.degenerate !== want.degenerate)
          report("degenerate", out_data.degenerate, want.degenerate);
      end
    end
  end

  // hold start high across back-to-back beats; drop it only while idling
  task automatic send_triple(crad_in_t t);
    @(negedge clk);
    start <= 1'b1;
    in_data <= t;
    // busy only moves at rising edges, so its value here holds at the next one
    while (busy) @(negedge clk);
    @(posedge clk);
    radius_q.push_back(circumradius(t));
    n_sent++;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      in_data <= crad_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (radius_q.size() != 0) @(posedge clk);
  endtask

  function automatic crad_in_t mk(int ax, int ay, int bx, int by, int cx, int cy);
    crad_in_t t;
    t.first_x = coord_t'(ax);  t.first_y = coord_t'(ay);
    t.middle_x = coord_t'(bx); t.middle_y = coord_t'(by);
    t.last_x = coord_t'(cx);   t.last_y = coord_t'(cy);
    return t;
  endfunction

  function automatic int rnd_coord();
    int s;
    s = $urandom_range(23, 2);
    return $signed($urandom) >>> (32 - s - 1);
  endfunction

  function automatic crad_in_t rnd_triple();
    int ax, ay, dx, dy, k;
    ax = rnd_coord(); ay = rnd_coord();
    case ($urandom_range(9))
      0: begin
        // collinear: last point on the line through the other two
        dx = $signed($urandom) >>> 20; dy = $signed($urandom) >>> 20;
        k = $signed($urandom_range(6)) - 3;
        return mk(ax, ay, ax + dx, ay + dy, ax + k * dx, ay + k * dy);
      end
      1: begin
        // nearly collinear: huge radius, often saturating
        dx = $signed($urandom) >>> 10; dy = $signed($urandom) >>> 10;
        return mk(ax, ay, ax + dx, ay + dy,
                  ax - dx + $signed($urandom_range(2)) - 1, ay - dy);
      end
      2: return mk(ax, ay, ax, ay, rnd_coord(), rnd_coord());
      3: return crad_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      default: return mk(ax, ay, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    endcase
  endfunction

  task automatic test_directed();
    localparam int MX = 8388607;
    localparam int MN = -8388608;
    idle_pct = 0;
    send_triple(mk(0, 0, 65536, 0, 0, 65536));
    send_triple(mk(0, 0, 1, 0, 0, 1));
    send_triple(mk(MN, MN, MX, MN, MN, MX));
    send_triple(mk(MX, MX, MN, MX, MX, MN));
    send_triple(mk(MN, 0, MX, 0, 0, MX));
    send_triple(mk(MN, MN, MX, MX, MN, MX));
    send_triple(mk(0, 0, 0, 0, 0, 0));
    send_triple(mk(MX, MX, MX, MX, MX, MX));
    send_triple(mk(5, 7, 5, 7, 100, -3));
    send_triple(mk(0, 0, 100, 100, 200, 200));
    send_triple(mk(MN, MN, 0, 0, MX, MX));
    send_triple(mk(MN, 0, MX, 0, 0, 1));
    send_triple(mk(MN, 0, MX, 0, 0, 0));
    send_triple(mk(MN, MN, MX, MX + 0, 0, 1));
    send_triple(mk(-1, -1, 1, 1, -1, 1));
    send_triple(mk(MN, MX, MX, MN, 0, 0));
    send_triple(mk(MN, MX, MX, MN, 1, 0));
    send_triple(mk(1, 0, 0, 1, -1, 0));
    send_triple(mk(MX, 0, MN, 1, MX, 2));
    send_triple(mk(-65536, -65536, 65536, 65536, 65536, -65536));
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    repeat (n) send_triple(rnd_triple());
  endtask

  task automatic test_pause();
    drain();
    repeat ($urandom_range(20, 5)) @(posedge clk);
    test_random(20, 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(180, 0);
    test_random(130, 85);
    test_pause();
    test_random(200, 33);
    drain();
    repeat (LATENCY + 20) @(posedge clk);
    $display("sent %0d point triples, checked %0d results (%0d degenerate)",
             n_sent, n_checked, n_degen);
    $display("covered extremes, collinear, coincident, saturation and random idle phases");
    if (errors == 0 && radius_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d errors, %0d results missing", errors, radius_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* circumradius_of_three_points.f */
rtl/crad_pkg.sv
rtl/crad_front.sv
rtl/crad_queue.sv
rtl/crad_mul.sv
rtl/crad_back.sv
rtl/circumradius_of_three_points.sv
bench/tb_circumradius_of_three_points.sv
